// ----- src/svo_pkg.sv -----
// ----------------------------------------------------------------------------
// svo_pkg
// Shared types and constants for the sound voice oscillator.
// ----------------------------------------------------------------------------
package svo_pkg;

    localparam int PHASE_W = 24;
    localparam int NOISE_W = 23;
    localparam int FREQ_W  = 16;
    localparam int PW_W    = 12;
    localparam int WAVE_W  = 12;
    localparam int CTRL_W  = 8;
    localparam int SEL_W   = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [NOISE_W-1:0] NOISE_SEED = 23'h7FFFF8;
    localparam logic [PW_W-1:0]    PW_MAX     = 12'hFFF;
    localparam logic [WAVE_W-1:0]  WAVE_FULL  = 12'hFFF;

    localparam logic [APB_AW-1:0] ADDR_FREQUENCY   = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_PULSE_WIDTH = 3'd4;

    localparam logic [SEL_W-1:0] SEL_TRIANGLE = 4'd1;
    localparam logic [SEL_W-1:0] SEL_SAW      = 4'd2;
    localparam logic [SEL_W-1:0] SEL_PULSE    = 4'd4;
    localparam logic [SEL_W-1:0] SEL_NOISE    = 4'd8;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CTRL  = 1'b1;

    localparam int CTRL_TEST_BIT = 3;
    localparam int CTRL_RING_BIT = 2;
    localparam int CTRL_SYNC_BIT = 1;

    typedef struct packed {
        logic              kind;
        logic [CTRL_W-1:0] control_byte;
        logic              source_counter_msb;
        logic              sync_pulse;
    } t_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_count;
        logic [PHASE_W-1:0] previous_phase;
        logic [NOISE_W-1:0] noise_shift;
        logic [SEL_W-1:0]   wave_select;
        logic               test_flag;
        logic               ring_flag;
        logic               sync_flag;
    } t_osc_state;

    typedef struct packed {
        t_osc_state state;
        logic       msb_rising;
    } t_step;

endpackage

// ----- src/svo_ifs.sv -----
// ----------------------------------------------------------------------------
// svo_ifs
// Item and result channels of the sound voice oscillator.
// ----------------------------------------------------------------------------
interface svo_in_if;
    import svo_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [CTRL_W-1:0] control_byte;
    logic              source_counter_msb;
    logic              sync_pulse;

    modport source (output valid, kind, control_byte, source_counter_msb, sync_pulse,
                    input ready);
    modport sink   (input valid, kind, control_byte, source_counter_msb, sync_pulse,
                    output ready);
endinterface

interface svo_out_if;
    import svo_pkg::*;

    logic              valid;
    logic              ready;
    logic [WAVE_W-1:0] wave_out;
    logic              msb_rising;
    logic              counter_msb;

    modport source (output valid, wave_out, msb_rising, counter_msb, input ready);
    modport sink   (input valid, wave_out, msb_rising, counter_msb, output ready);
endinterface

// ----- src/svo_regs.sv -----
// ----------------------------------------------------------------------------
// svo_regs
// APB register file: frequency word and pulse width.
// ----------------------------------------------------------------------------
module svo_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svo_pkg::APB_AW-1:0]    paddr,
    input  logic [svo_pkg::APB_DW-1:0]    pwdata,
    output logic [svo_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [svo_pkg::FREQ_W-1:0]    o_frequency,
    output logic [svo_pkg::PW_W-1:0]      o_pulse_width
);
    import svo_pkg::*;

    logic [FREQ_W-1:0] r_frequency;
    logic [PW_W-1:0]   r_pulse_width;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frequency   <= '0;
            r_pulse_width <= '0;
        end else if (wr_en) begin
            unique case (paddr)
                ADDR_FREQUENCY:   r_frequency   <= pwdata[FREQ_W-1:0];
                ADDR_PULSE_WIDTH: r_pulse_width <= pwdata[PW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_FREQUENCY:   prdata = {{(APB_DW-FREQ_W){1'b0}}, r_frequency};
            ADDR_PULSE_WIDTH: prdata = {{(APB_DW-PW_W){1'b0}}, r_pulse_width};
            default:          prdata = '0;
        endcase
    end

    assign o_frequency   = r_frequency;
    assign o_pulse_width = r_pulse_width;

endmodule

// ----- src/svo_state.sv -----
// ----------------------------------------------------------------------------
// svo_state
// Oscillator state: phase accumulator, noise LFSR and control flags.
// ----------------------------------------------------------------------------
module svo_state (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  svo_pkg::t_item             i_item,
    input  logic [svo_pkg::FREQ_W-1:0] i_frequency,
    output svo_pkg::t_step             o_step
);
    import svo_pkg::*;

    t_osc_state r_state;
    t_osc_state n_state;
    logic       rising;

    always_comb begin
        n_state = r_state;
        rising  = 1'b0;
        if (i_item.kind == KIND_CTRL) begin
            n_state.wave_select = i_item.control_byte[CTRL_W-1 -: SEL_W];
            if (i_item.control_byte[CTRL_TEST_BIT]) begin
                n_state.phase_count = '0;
                n_state.noise_shift = '0;
            end else if (r_state.test_flag) begin
                n_state.noise_shift = NOISE_SEED;
            end
            n_state.test_flag = i_item.control_byte[CTRL_TEST_BIT];
            n_state.ring_flag = i_item.control_byte[CTRL_RING_BIT];
            n_state.sync_flag = i_item.control_byte[CTRL_SYNC_BIT];
        end else begin
            if (!r_state.test_flag) begin
                n_state.previous_phase = r_state.phase_count;
                n_state.phase_count    = r_state.phase_count
                                       + {{(PHASE_W-FREQ_W){1'b0}}, i_frequency};
            end
            rising = !n_state.previous_phase[PHASE_W-1] && n_state.phase_count[PHASE_W-1];
            // noise clocks on the rising edge of phase bit 19
            if (!n_state.previous_phase[19] && n_state.phase_count[19]) begin
                n_state.noise_shift = {r_state.noise_shift[NOISE_W-2:0],
                                       r_state.noise_shift[22] ^ r_state.noise_shift[17]};
            end
            if (i_item.sync_pulse && r_state.sync_flag) begin
                n_state.phase_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase_count    <= '0;
            r_state.previous_phase <= '0;
            r_state.noise_shift    <= NOISE_SEED;
            r_state.wave_select    <= '0;
            r_state.test_flag      <= 1'b0;
            r_state.ring_flag      <= 1'b0;
            r_state.sync_flag      <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_step.state      = n_state;
    assign o_step.msb_rising = rising;

    a_test_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.kind == KIND_TICK && r_state.test_flag
         && !(i_item.sync_pulse && r_state.sync_flag))
        |=> (r_state.phase_count == $past(r_state.phase_count)))
        else $error("phase moved while test bit set");

    a_test_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.kind == KIND_CTRL && i_item.control_byte[CTRL_TEST_BIT])
        |=> (r_state.phase_count == '0 && r_state.noise_shift == '0 && r_state.test_flag))
        else $error("test bit write did not clear phase and noise");

    a_noise_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.test_flag |-> (r_state.noise_shift != '0))
        else $error("noise register stuck at zero");

endmodule

// ----- src/svo_wave.sv -----
// ----------------------------------------------------------------------------
// svo_wave
// Waveform select: triangle, saw, pulse and noise outputs.
// ----------------------------------------------------------------------------
module svo_wave (
    input  svo_pkg::t_osc_state        i_state,
    input  logic [svo_pkg::PW_W-1:0]   i_pulse_width,
    input  logic                       i_source_msb,
    output logic [svo_pkg::WAVE_W-1:0] o_wave
);
    import svo_pkg::*;

    logic              tri_msb;
    logic [WAVE_W-1:0] tri_val;
    logic [WAVE_W-1:0] top;
    logic [WAVE_W-1:0] noise_val;
    logic [NOISE_W-1:0] s;

    assign s       = i_state.noise_shift;
    assign top     = i_state.phase_count[PHASE_W-1 -: WAVE_W];
    assign tri_msb = i_state.phase_count[PHASE_W-1] ^ (i_state.ring_flag & i_source_msb);
    assign tri_val = tri_msb ? ~i_state.phase_count[PHASE_W-2 -: WAVE_W]
                             :  i_state.phase_count[PHASE_W-2 -: WAVE_W];
    assign noise_val = {s[22], s[20], s[16], s[13], s[11], s[7], s[4], s[2], 4'b0000};

    always_comb begin
        case (i_state.wave_select)
            SEL_TRIANGLE: o_wave = tri_val;
            SEL_SAW:      o_wave = top;
            SEL_PULSE:    o_wave = (i_pulse_width == PW_MAX || top >= i_pulse_width)
                                   ? WAVE_FULL : '0;
            SEL_NOISE:    o_wave = noise_val;
            default:      o_wave = '0;
        endcase
    end

endmodule

// ----- src/sound_voice_oscillator.sv -----
// ----------------------------------------------------------------------------
// sound_voice_oscillator
// One voice oscillator: 24-bit phase accumulator, 23-bit noise LFSR and
// triangle / saw / pulse / noise waveform output, one result per item.
// ----------------------------------------------------------------------------
// Every item (tick or control write) passes through an input register, the
// combinational state update and waveform logic, and a result register; the
// result register loads when it is empty or its last result is being taken,
// and one item is taken per clock when the result side keeps up. The phase,
// noise and flag registers update at the edge where the item moves into the
// result register, so consecutive items see each other's effect with no gap.
// The user must write frequency and pulse width over APB only while no item is
// in flight; the block itself does not enforce it.
module sound_voice_oscillator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svo_pkg::APB_AW-1:0]    paddr,
    input  logic [svo_pkg::APB_DW-1:0]    pwdata,
    output logic [svo_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    svo_in_if.sink                        i_in,
    svo_out_if.source                     o_out
);
    import svo_pkg::*;

    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    logic [WAVE_W-1:0] r_wave;
    logic              r_rising;
    logic              r_msb;

    logic              advance;
    logic              step;
    logic [FREQ_W-1:0] frequency;
    logic [PW_W-1:0]   pulse_width;
    t_step             step_res;
    logic [WAVE_W-1:0] wave;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.kind               <= i_in.kind;
            r_in.control_byte       <= i_in.control_byte;
            r_in.source_counter_msb <= i_in.source_counter_msb;
            r_in.sync_pulse         <= i_in.sync_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_wave   <= wave;
            r_rising <= step_res.msb_rising;
            r_msb    <= step_res.state.phase_count[PHASE_W-1];
        end
    end

    svo_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_frequency   (frequency),
        .o_pulse_width (pulse_width)
    );

    svo_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_frequency (frequency),
        .o_step      (step_res)
    );

    svo_wave u_wave (
        .i_state       (step_res.state),
        .i_pulse_width (pulse_width),
        .i_source_msb  (r_in.source_counter_msb),
        .o_wave        (wave)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.wave_out    = r_wave;
    assign o_out.msb_rising  = r_rising;
    assign o_out.counter_msb = r_msb;

endmodule

// ----- sim/svo_voice_checker.sv -----
// ----------------------------------------------------------------------------
// svo_voice_checker
// Watches the APB port and both channels of the voice oscillator, predicts
// the waveform, MSB edge and MSB bit of every accepted item, and compares
// each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module svo_voice_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [svo_pkg::APB_AW-1:0] paddr,
    input  logic [svo_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    svo_in_if                          i_in,
    svo_out_if                         i_out,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import svo_pkg::*;

    typedef struct packed {
        logic [WAVE_W-1:0] wave;
        logic              rising;
        logic              msb;
    } t_wave_result;

    logic [PHASE_W-1:0] phase_acc;
    logic [PHASE_W-1:0] phase_prev;
    logic [NOISE_W-1:0] lfsr;
    logic [SEL_W-1:0]   sel;
    logic               test_on;
    logic               ring_on;
    logic               sync_on;
    logic [FREQ_W-1:0]  freq_word;
    logic [PW_W-1:0]    pw_level;

    t_wave_result wave_due_q[$];
    t_wave_result want;
    t_wave_result got;
    t_item        in_item;
    int           mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [WAVE_W-1:0] wave_level(logic src_msb);
        logic tri_msb;
        tri_msb = phase_acc[PHASE_W-1] ^ (ring_on & src_msb);
        case (sel)
            SEL_TRIANGLE: return tri_msb ? ~phase_acc[22:11] : phase_acc[22:11];
            SEL_SAW:      return phase_acc[23:12];
            SEL_PULSE: begin
                if (pw_level == PW_MAX || phase_acc[23:12] >= pw_level) begin
                    return WAVE_FULL;
                end
                return '0;
            end
            SEL_NOISE: return {lfsr[22], lfsr[20], lfsr[16], lfsr[13],
                               lfsr[11], lfsr[7], lfsr[4], lfsr[2], 4'b0000};
            default:   return '0;
        endcase
    endfunction

    task automatic advance_voice(input t_item it, output t_wave_result r);
        logic rose;
        rose = 1'b0;
        if (it.kind == KIND_CTRL) begin
            sel = it.control_byte[7:4];
            if (it.control_byte[CTRL_TEST_BIT]) begin
                phase_acc = '0;
                lfsr      = '0;
            end else if (test_on) begin
                lfsr = NOISE_SEED;
            end
            test_on = it.control_byte[CTRL_TEST_BIT];
            ring_on = it.control_byte[CTRL_RING_BIT];
            sync_on = it.control_byte[CTRL_SYNC_BIT];
        end else begin
            if (!test_on) begin
                phase_prev = phase_acc;
                phase_acc  = phase_acc + PHASE_W'(freq_word);
            end
            rose = !phase_prev[23] && phase_acc[23];
            if (!phase_prev[19] && phase_acc[19]) begin
                lfsr = {lfsr[21:0], lfsr[22] ^ lfsr[17]};
            end
            if (it.sync_pulse && sync_on) begin
                phase_acc = '0;
            end
        end
        r.wave   = wave_level(it.source_counter_msb);
        r.rising = rose;
        r.msb    = phase_acc[PHASE_W-1];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_acc  = '0;
            phase_prev = '0;
            lfsr       = NOISE_SEED;
            sel        = '0;
            test_on    = 1'b0;
            ring_on    = 1'b0;
            sync_on    = 1'b0;
            freq_word  = '0;
            pw_level   = '0;
            wave_due_q.delete();
            o_outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_FREQUENCY:   freq_word = pwdata[FREQ_W-1:0];
                    ADDR_PULSE_WIDTH: pw_level  = pwdata[PW_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.wave   = i_out.wave_out;
                got.rising = i_out.msb_rising;
                got.msb    = i_out.counter_msb;
                if (wave_due_q.size() == 0) begin
                    $display("%0t: result transfer with none expected: wave %h rise %b msb %b",
                             $time, got.wave, got.rising, got.msb);
                    mismatches++;
                end else begin
                    want = wave_due_q.pop_front();
                    if (got.wave !== want.wave) begin
                        $display("%0t: wave_out expected %h actual %h",
                                 $time, want.wave, got.wave);
                        mismatches++;
                    end
                    if (got.rising !== want.rising) begin
                        $display("%0t: msb_rising expected %b actual %b",
                                 $time, want.rising, got.rising);
                        mismatches++;
                    end
                    if (got.msb !== want.msb) begin
                        $display("%0t: counter_msb expected %b actual %b",
                                 $time, want.msb, got.msb);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                in_item.kind               = i_in.kind;
                in_item.control_byte       = i_in.control_byte;
                in_item.source_counter_msb = i_in.source_counter_msb;
                in_item.sync_pulse         = i_in.sync_pulse;
                advance_voice(in_item, want);
                wave_due_q.push_back(want);
            end
            o_outstanding <= wave_due_q.size();
        end
    end

endmodule

// ----- sim/sound_voice_oscillator_tb.sv -----
// ----------------------------------------------------------------------------
// sound_voice_oscillator_tb
// Drives the voice oscillator with a directed set of control writes and
// ticks, then random item streams under several frequency and pulse width
// settings and three sender/receiver stall mixes; the checker scores results.
// ----------------------------------------------------------------------------
module sound_voice_oscillator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import svo_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 17;
    localparam int SEG_ITEMS    = 100;
    localparam int SETTLE_TICKS = 4;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    int                 fail_count;
    int                 outstanding;
    int                 snd_idle_pct;
    int                 rcv_idle_pct;
    int                 cycle_count = 0;

    svo_in_if  in_ch ();
    svo_out_if out_ch ();

    sound_voice_oscillator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    svo_voice_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sound_voice_oscillator_tb failed");
        $finish;
    end

    function automatic logic [CTRL_W-1:0] ctrl_byte(logic [SEL_W-1:0] wsel, logic test,
                                                    logic ring, logic sync);
        logic [CTRL_W-1:0] b;
        b = {wsel, 4'b0000};
        b[CTRL_TEST_BIT] = test;
        b[CTRL_RING_BIT] = ring;
        b[CTRL_SYNC_BIT] = sync;
        return b;
    endfunction

    function automatic t_item voice_item(logic kind, logic [CTRL_W-1:0] cb,
                                         logic src, logic sync);
        t_item it;
        it.kind               = kind;
        it.control_byte       = cb;
        it.source_counter_msb = src;
        it.sync_pulse         = sync;
        return it;
    endfunction

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.kind               <= it.kind;
        in_ch.control_byte       <= it.control_byte;
        in_ch.source_counter_msb <= it.source_counter_msb;
        in_ch.sync_pulse         <= it.sync_pulse;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    initial begin
        t_item             it;
        logic [CTRL_W-1:0] cb;
        logic [SEL_W-1:0]  wsel;
        logic [FREQ_W-1:0] freq;
        logic [PW_W-1:0]   pw;

        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        in_ch.valid              <= 1'b0;
        in_ch.kind               <= KIND_TICK;
        in_ch.control_byte       <= '0;
        in_ch.source_counter_msb <= 1'b0;
        in_ch.sync_pulse         <= 1'b0;
        snd_idle_pct = 28;
        rcv_idle_pct = 73;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each waveform, ring, test set and release, sync, odd selectors
        apb_write(ADDR_FREQUENCY, 32'(16'hFFFF));
        apb_write(ADDR_PULSE_WIDTH, 32'(12'h800));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_SAW, 1'b0, 1'b0, 1'b0), 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b1, 1'b0));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_TRIANGLE, 1'b0, 1'b1, 1'b0), 1'b1, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b1, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_PULSE, 1'b0, 1'b0, 1'b0), 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_NOISE, 1'b0, 1'b0, 1'b0), 1'b0, 1'b0));
        repeat (3) send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_TRIANGLE | SEL_SAW, 1'b0, 1'b0, 1'b0),
                             1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_CTRL,
                             ctrl_byte(SEL_NOISE | SEL_PULSE | SEL_SAW | SEL_TRIANGLE,
                                       1'b0, 1'b0, 1'b0) | 8'h01, 1'b1, 1'b1));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_SAW, 1'b1, 1'b0, 1'b1), 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b1));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_NOISE, 1'b0, 1'b0, 1'b1), 1'b0, 1'b1));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b1));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));
        send_item(voice_item(KIND_CTRL, ctrl_byte(SEL_PULSE, 1'b0, 1'b0, 1'b0), 1'b0, 1'b0));
        send_item(voice_item(KIND_TICK, '0, 1'b0, 1'b0));

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            if (seg < 6) begin
                snd_idle_pct = 28;
                rcv_idle_pct = 73;
            end else if (seg < 12) begin
                snd_idle_pct = 73;
                rcv_idle_pct = 28;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case (seg % 5)
                0: begin
                    freq = 16'hFFFF;
                    pw   = '0;
                end
                1: begin
                    freq = 16'($urandom_range(65535));
                    pw   = PW_MAX;
                end
                2: begin
                    freq = '0;
                    pw   = 12'($urandom_range(4095));
                end
                default: begin
                    freq = 16'($urandom_range(65535, 8192));
                    pw   = 12'($urandom_range(4095));
                end
            endcase
            apb_write(ADDR_FREQUENCY, 32'(freq));
            apb_write(ADDR_PULSE_WIDTH, 32'(pw));

            for (int n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(99) < 12) begin
                    if ($urandom_range(3) == 0) begin
                        cb = CTRL_W'($urandom_range(255));
                    end else begin
                        case ($urandom_range(3))
                            0:       wsel = SEL_TRIANGLE;
                            1:       wsel = SEL_SAW;
                            2:       wsel = SEL_PULSE;
                            default: wsel = SEL_NOISE;
                        endcase
                        cb = ctrl_byte(wsel, $urandom_range(99) < 8,
                                       1'($urandom_range(1)), 1'($urandom_range(1)));
                        cb[0] = 1'($urandom_range(1));
                    end
                    it = voice_item(KIND_CTRL, cb, 1'($urandom_range(1)),
                                    1'($urandom_range(1)));
                end else begin
                    it = voice_item(KIND_TICK, CTRL_W'($urandom_range(255)),
                                    1'($urandom_range(1)), $urandom_range(99) < 4);
                end
                send_item(it);
                if ($urandom_range(199) == 0) begin
                    drain();
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("sound_voice_oscillator_tb passed");
        end else begin
            $display("sound_voice_oscillator_tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/svo_pkg.sv
src/svo_ifs.sv
src/svo_regs.sv
src/svo_state.sv
src/svo_wave.sv
src/sound_voice_oscillator.sv
sim/svo_voice_checker.sv
sim/sound_voice_oscillator_tb.sv
